// ===== src/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared constants, reciprocal multipliers, sector codes and the item
// structures that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	// Geometry of the hue circle and level range
	localparam int unsigned HUE_FULL_TURN  = 360;
	localparam int unsigned SECTOR_DEGREES = 60;
	localparam int unsigned LEVEL_MAX      = 255;
	localparam int unsigned FRACTION_SCALE = LEVEL_MAX * SECTOR_DEGREES;

	// Field widths
	localparam int unsigned HUE_W   = 16;
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned REM_W   = 9;   // hue mod 360
	localparam int unsigned OFS_W   = 6;   // offset within sector, 0..59
	localparam int unsigned QUO_W   = 8;   // hue / 360 for a 16-bit hue
	localparam int unsigned FRAC_W  = 14;  // up to FRACTION_SCALE
	localparam int unsigned PNUM_W  = 16;  // v * (255 - s)
	localparam int unsigned QNUM_W  = 22;  // v * (15300 - ...)
	localparam int unsigned PIXEL_W = 24;

	// Exact floor division by constants: ceil(2^N / d), N chosen so that
	// the rounding excess times the largest dividend stays below 2^N.
	localparam int unsigned HUE_SHIFT  = 25;
	localparam int unsigned HUE_RECIP_W = 17;
	localparam logic [HUE_RECIP_W-1:0] HUE_RECIP = HUE_RECIP_W'(
		((64'd1 << HUE_SHIFT) + 64'(HUE_FULL_TURN) - 64'd1) / 64'(HUE_FULL_TURN));

	localparam int unsigned LEVEL_SHIFT   = 24;
	localparam int unsigned LEVEL_RECIP_W = 17;
	localparam logic [LEVEL_RECIP_W-1:0] LEVEL_RECIP = LEVEL_RECIP_W'(
		((64'd1 << LEVEL_SHIFT) + 64'(LEVEL_MAX) - 64'd1) / 64'(LEVEL_MAX));

	localparam int unsigned FRAC_SHIFT   = 36;
	localparam int unsigned FRAC_RECIP_W = 23;
	localparam logic [FRAC_RECIP_W-1:0] FRAC_RECIP = FRAC_RECIP_W'(
		((64'd1 << FRAC_SHIFT) + 64'(FRACTION_SCALE) - 64'd1) / 64'(FRACTION_SCALE));

	// Output formats
	localparam logic FMT_RGB888 = 1'b0;
	localparam logic FMT_RGB565 = 1'b1;

	// 60-degree sectors of the hue circle
	typedef enum logic [2:0] {
		SECTOR_RED     = 3'd0,
		SECTOR_YELLOW  = 3'd1,
		SECTOR_GREEN   = 3'd2,
		SECTOR_CYAN    = 3'd3,
		SECTOR_BLUE    = 3'd4,
		SECTOR_MAGENTA = 3'd5
	} sector_t;

	// Item leaving the hue section
	typedef struct packed {
		logic                valid;
		sector_t             sector;
		logic [OFS_W-1:0]    offset;
		logic [LEVEL_W-1:0]  sat;
		logic [LEVEL_W-1:0]  val;
	} sect_item_t;

	// Item leaving the level section
	typedef struct packed {
		logic                valid;
		sector_t             sector;
		logic [LEVEL_W-1:0]  val;
		logic [LEVEL_W-1:0]  lvl_p;
		logic [LEVEL_W-1:0]  lvl_q;
		logic [LEVEL_W-1:0]  lvl_t;
	} level_item_t;

endpackage

// ===== src/hsv2rgb_sector.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB hue section
// Reduces the hue modulo 360 by reciprocal multiplication, then splits it
// into a 60-degree sector and an offset within that sector. Two stages.
// ----------------------------------------------------------------------------
module hsv2rgb_sector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [hsv2rgb_pkg::HUE_W-1:0]       hue,
	input  logic [hsv2rgb_pkg::LEVEL_W-1:0]     sat,
	input  logic [hsv2rgb_pkg::LEVEL_W-1:0]     val,
	output hsv2rgb_pkg::sect_item_t             item
);

	localparam int unsigned PROD_W = hsv2rgb_pkg::HUE_W + hsv2rgb_pkg::HUE_RECIP_W;

	logic                               valid_s1;
	logic [hsv2rgb_pkg::HUE_W-1:0]      hue_s1;
	logic [hsv2rgb_pkg::QUO_W-1:0]      quo_s1;
	logic [hsv2rgb_pkg::LEVEL_W-1:0]    sat_s1;
	logic [hsv2rgb_pkg::LEVEL_W-1:0]    val_s1;

	logic [PROD_W-1:0]                  quo_prod;
	logic [hsv2rgb_pkg::HUE_W-1:0]      rem_full;
	logic [hsv2rgb_pkg::REM_W-1:0]      rem;
	logic [hsv2rgb_pkg::REM_W-1:0]      base;
	hsv2rgb_pkg::sector_t               sector;

	logic                               valid_s2;
	hsv2rgb_pkg::sector_t               sector_s2;
	logic [hsv2rgb_pkg::OFS_W-1:0]      offset_s2;
	logic [hsv2rgb_pkg::LEVEL_W-1:0]    sat_s2;
	logic [hsv2rgb_pkg::LEVEL_W-1:0]    val_s2;

	// Quotient of hue by a full turn
	assign quo_prod = PROD_W'(hue) * PROD_W'(hsv2rgb_pkg::HUE_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: capture the item and the quotient
	always_ff @(posedge clk) begin
		if (en) begin
			hue_s1 <= hue;
			sat_s1 <= sat;
			val_s1 <= val;
			quo_s1 <= quo_prod[hsv2rgb_pkg::HUE_SHIFT +: hsv2rgb_pkg::QUO_W];
		end
	end

	// Remainder, then sector by comparison against the sector starts
	assign rem_full = hue_s1 - hsv2rgb_pkg::HUE_W'(
		{{(hsv2rgb_pkg::HUE_W-hsv2rgb_pkg::QUO_W){1'b0}}, quo_s1}
		* hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::HUE_FULL_TURN));
	assign rem = rem_full[hsv2rgb_pkg::REM_W-1:0];

	always_comb begin
		if (rem >= hsv2rgb_pkg::REM_W'(5 * hsv2rgb_pkg::SECTOR_DEGREES)) begin
			sector = hsv2rgb_pkg::SECTOR_MAGENTA;
			base   = hsv2rgb_pkg::REM_W'(5 * hsv2rgb_pkg::SECTOR_DEGREES);
		end else if (rem >= hsv2rgb_pkg::REM_W'(4 * hsv2rgb_pkg::SECTOR_DEGREES)) begin
			sector = hsv2rgb_pkg::SECTOR_BLUE;
			base   = hsv2rgb_pkg::REM_W'(4 * hsv2rgb_pkg::SECTOR_DEGREES);
		end else if (rem >= hsv2rgb_pkg::REM_W'(3 * hsv2rgb_pkg::SECTOR_DEGREES)) begin
			sector = hsv2rgb_pkg::SECTOR_CYAN;
			base   = hsv2rgb_pkg::REM_W'(3 * hsv2rgb_pkg::SECTOR_DEGREES);
		end else if (rem >= hsv2rgb_pkg::REM_W'(2 * hsv2rgb_pkg::SECTOR_DEGREES)) begin
			sector = hsv2rgb_pkg::SECTOR_GREEN;
			base   = hsv2rgb_pkg::REM_W'(2 * hsv2rgb_pkg::SECTOR_DEGREES);
		end else if (rem >= hsv2rgb_pkg::REM_W'(hsv2rgb_pkg::SECTOR_DEGREES)) begin
			sector = hsv2rgb_pkg::SECTOR_YELLOW;
			base   = hsv2rgb_pkg::REM_W'(hsv2rgb_pkg::SECTOR_DEGREES);
		end else begin
			sector = hsv2rgb_pkg::SECTOR_RED;
			base   = '0;
		end
	end

	// Stage 2: sector and offset
	always_ff @(posedge clk) begin
		if (en) begin
			sector_s2 <= sector;
			offset_s2 <= hsv2rgb_pkg::OFS_W'(rem - base);
			sat_s2    <= sat_s1;
			val_s2    <= val_s1;
		end
	end

	assign item.valid  = valid_s2;
	assign item.sector = sector_s2;
	assign item.offset = offset_s2;
	assign item.sat    = sat_s2;
	assign item.val    = val_s2;

endmodule

// ===== src/hsv2rgb_level.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB level section
// Computes the p, q and t levels: fraction products, value products and
// exact floor division by reciprocal multiplication. Three stages.
// ----------------------------------------------------------------------------
module hsv2rgb_level (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  hsv2rgb_pkg::sect_item_t     item_in,
	output hsv2rgb_pkg::level_item_t    item_out
);

	localparam int unsigned LW   = hsv2rgb_pkg::LEVEL_W;
	localparam int unsigned FW   = hsv2rgb_pkg::FRAC_W;
	localparam int unsigned PW   = hsv2rgb_pkg::PNUM_W;
	localparam int unsigned QW   = hsv2rgb_pkg::QNUM_W;
	localparam int unsigned PPW  = PW + hsv2rgb_pkg::LEVEL_RECIP_W;
	localparam int unsigned QPW  = QW + hsv2rgb_pkg::FRAC_RECIP_W;
	localparam int unsigned OFS_RW = hsv2rgb_pkg::OFS_W;

	logic                       valid_s3;
	hsv2rgb_pkg::sector_t       sector_s3;
	logic [LW-1:0]              val_s3;
	logic [LW-1:0]              inv_sat_s3;
	logic [FW-1:0]              sm_s3;
	logic [FW-1:0]              smr_s3;

	logic                       valid_s4;
	hsv2rgb_pkg::sector_t       sector_s4;
	logic [LW-1:0]              val_s4;
	logic [PW-1:0]              pnum_s4;
	logic [QW-1:0]              qnum_s4;
	logic [QW-1:0]              tnum_s4;

	logic                       valid_s5;
	hsv2rgb_pkg::sector_t       sector_s5;
	logic [LW-1:0]              val_s5;
	logic [LW-1:0]              p_s5;
	logic [LW-1:0]              q_s5;
	logic [LW-1:0]              t_s5;

	logic [OFS_RW-1:0]          rest_ofs;
	logic [FW-1:0]              frac_q;
	logic [FW-1:0]              frac_t;
	logic [PPW-1:0]             p_prod;
	logic [QPW-1:0]             q_prod;
	logic [QPW-1:0]             t_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s3 <= item_in.valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Distance to the end of the sector
	assign rest_ofs = OFS_RW'(hsv2rgb_pkg::SECTOR_DEGREES) - item_in.offset;

	// Stage 3: saturation times the offsets
	always_ff @(posedge clk) begin
		if (en) begin
			sector_s3  <= item_in.sector;
			val_s3     <= item_in.val;
			inv_sat_s3 <= LW'(hsv2rgb_pkg::LEVEL_MAX) - item_in.sat;
			sm_s3      <= FW'(item_in.sat) * FW'(item_in.offset);
			smr_s3     <= FW'(item_in.sat) * FW'(rest_ofs);
		end
	end

	assign frac_q = FW'(hsv2rgb_pkg::FRACTION_SCALE) - sm_s3;
	assign frac_t = FW'(hsv2rgb_pkg::FRACTION_SCALE) - smr_s3;

	// Stage 4: value times the fractions
	always_ff @(posedge clk) begin
		if (en) begin
			sector_s4 <= sector_s3;
			val_s4    <= val_s3;
			pnum_s4   <= PW'(val_s3) * PW'(inv_sat_s3);
			qnum_s4   <= QW'(val_s3) * QW'(frac_q);
			tnum_s4   <= QW'(val_s3) * QW'(frac_t);
		end
	end

	// Floor division by reciprocal multiplication
	assign p_prod = PPW'(pnum_s4) * PPW'(hsv2rgb_pkg::LEVEL_RECIP);
	assign q_prod = QPW'(qnum_s4) * QPW'(hsv2rgb_pkg::FRAC_RECIP);
	assign t_prod = QPW'(tnum_s4) * QPW'(hsv2rgb_pkg::FRAC_RECIP);

	// Stage 5: levels
	always_ff @(posedge clk) begin
		if (en) begin
			sector_s5 <= sector_s4;
			val_s5    <= val_s4;
			p_s5      <= p_prod[hsv2rgb_pkg::LEVEL_SHIFT +: LW];
			q_s5      <= q_prod[hsv2rgb_pkg::FRAC_SHIFT +: LW];
			t_s5      <= t_prod[hsv2rgb_pkg::FRAC_SHIFT +: LW];
		end
	end

	assign item_out.valid  = valid_s5;
	assign item_out.sector = sector_s5;
	assign item_out.val    = val_s5;
	assign item_out.lvl_p  = p_s5;
	assign item_out.lvl_q  = q_s5;
	assign item_out.lvl_t  = t_s5;

endmodule

// ===== src/hsv_to_rgb_converter_core.sv =====
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the six-stage pipeline advances as a whole
// and holds only while a waiting output item is stalled.
// Reset: arst_n clears all valid bits and selects RGB888 output.
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Hue and level sections followed by sector routing and pixel packing.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [hsv2rgb_pkg::HUE_W-1:0]       hue_degrees,
	input  logic [hsv2rgb_pkg::LEVEL_W-1:0]     sat_level,
	input  logic [hsv2rgb_pkg::LEVEL_W-1:0]     bright_level,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [hsv2rgb_pkg::PIXEL_W-1:0]     pixel_word
);

	localparam int unsigned LW = hsv2rgb_pkg::LEVEL_W;

	logic                           en;
	logic                           fmt_q;
	hsv2rgb_pkg::sect_item_t        sect_item;
	hsv2rgb_pkg::level_item_t       level_item;
	logic [LW-1:0]                  red;
	logic [LW-1:0]                  green;
	logic [LW-1:0]                  blue;
	logic [hsv2rgb_pkg::PIXEL_W-1:0] packed_px;
	logic                           valid_s6;
	logic [hsv2rgb_pkg::PIXEL_W-1:0] pixel_s6;

	// Advance unless a finished item is held at the output
	assign en       = !(valid_s6 && out_stall);
	assign in_stall = !en;

	// Output format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= hsv2rgb_pkg::FMT_RGB888;
		end else if (cfg_wr_en) begin
			fmt_q <= cfg_wr_data;
		end
	end

	hsv2rgb_sector u_sector (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.hue      (hue_degrees),
		.sat      (sat_level),
		.val      (bright_level),
		.item     (sect_item)
	);

	hsv2rgb_level u_level (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.item_in  (sect_item),
		.item_out (level_item)
	);

	// Route levels to the channels by sector
	always_comb begin
		case (level_item.sector)
			hsv2rgb_pkg::SECTOR_RED: begin
				red = level_item.val; green = level_item.lvl_t; blue = level_item.lvl_p;
			end
			hsv2rgb_pkg::SECTOR_YELLOW: begin
				red = level_item.lvl_q; green = level_item.val; blue = level_item.lvl_p;
			end
			hsv2rgb_pkg::SECTOR_GREEN: begin
				red = level_item.lvl_p; green = level_item.val; blue = level_item.lvl_t;
			end
			hsv2rgb_pkg::SECTOR_CYAN: begin
				red = level_item.lvl_p; green = level_item.lvl_q; blue = level_item.val;
			end
			hsv2rgb_pkg::SECTOR_BLUE: begin
				red = level_item.lvl_t; green = level_item.lvl_p; blue = level_item.val;
			end
			default: begin
				red = level_item.val; green = level_item.lvl_p; blue = level_item.lvl_q;
			end
		endcase
	end

	// Pack as RGB888 or RGB565
	always_comb begin
		if (fmt_q == hsv2rgb_pkg::FMT_RGB565) begin
			packed_px = {8'h00, red[7:3], green[7:2], blue[7:3]};
		end else begin
			packed_px = {red, green, blue};
		end
	end

	// Stage 6: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= level_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_s6 <= packed_px;
		end
	end

	assign out_valid  = valid_s6;
	assign pixel_word = pixel_s6;

endmodule

// ===== tb/hsv_to_rgb_converter_core_tb.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter core testbench
// Feeds HSV pixels through the valid/stall input channel and checks every
// output pixel word against a local integer predictor. The pixel format is
// changed between phases, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core_tb;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned IDLE_PCT     = 28;
	localparam int unsigned PHASE_ITEMS  = 350;
	localparam int unsigned HUE_W        = hsv2rgb_pkg::HUE_W;
	localparam int unsigned LEVEL_W      = hsv2rgb_pkg::LEVEL_W;
	localparam int unsigned PIXEL_W      = hsv2rgb_pkg::PIXEL_W;

	typedef struct packed {
		logic [HUE_W-1:0]   hue;
		logic [LEVEL_W-1:0] sat;
		logic [LEVEL_W-1:0] bright;
	} hsv_pixel_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_wr_en    = 1'b0;
	logic               cfg_wr_data  = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic [HUE_W-1:0]   hue_degrees  = '0;
	logic [LEVEL_W-1:0] sat_level    = '0;
	logic [LEVEL_W-1:0] bright_level = '0;
	logic               out_valid;
	logic               out_stall    = 1'b0;
	logic [PIXEL_W-1:0] pixel_word;

	hsv_pixel_t         pixels_to_send[$];
	logic [PIXEL_W-1:0] pixels_due[$];
	logic               format_sel   = hsv2rgb_pkg::FMT_RGB888;
	logic               steady_flow  = 1'b0;
	int unsigned        error_count  = 0;
	int unsigned        pixels_seen  = 0;
	int unsigned        rgb565_seen  = 0;
	int unsigned        format_writes = 0;
	int unsigned        cycle_count  = 0;

	hsv_to_rgb_converter_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.hue_degrees  (hue_degrees),
		.sat_level    (sat_level),
		.bright_level (bright_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_word   (pixel_word)
	);

	// Expected pixel word for one HSV pixel in the given format
	function automatic logic [PIXEL_W-1:0] rgb_from_hsv(input hsv_pixel_t px, input logic fmt);
		int unsigned hue, s, v, ofs, low_lvl, fall_lvl, rise_lvl;
		hsv2rgb_pkg::sector_t sect;
		logic [7:0]  r, g, b;
		hue = 32'(px.hue) % hsv2rgb_pkg::HUE_FULL_TURN;
		s = 32'(px.sat);
		v = 32'(px.bright);
		sect = hsv2rgb_pkg::sector_t'(hue / hsv2rgb_pkg::SECTOR_DEGREES);
		ofs = hue % hsv2rgb_pkg::SECTOR_DEGREES;
		low_lvl  = v * (hsv2rgb_pkg::LEVEL_MAX - s) / hsv2rgb_pkg::LEVEL_MAX;
		fall_lvl = v * (hsv2rgb_pkg::FRACTION_SCALE - s * ofs)
			/ hsv2rgb_pkg::FRACTION_SCALE;
		rise_lvl = v * (hsv2rgb_pkg::FRACTION_SCALE
			- s * (hsv2rgb_pkg::SECTOR_DEGREES - ofs)) / hsv2rgb_pkg::FRACTION_SCALE;
		case (sect)
			hsv2rgb_pkg::SECTOR_RED: begin
				r = 8'(v); g = 8'(rise_lvl); b = 8'(low_lvl);
			end
			hsv2rgb_pkg::SECTOR_YELLOW: begin
				r = 8'(fall_lvl); g = 8'(v); b = 8'(low_lvl);
			end
			hsv2rgb_pkg::SECTOR_GREEN: begin
				r = 8'(low_lvl); g = 8'(v); b = 8'(rise_lvl);
			end
			hsv2rgb_pkg::SECTOR_CYAN: begin
				r = 8'(low_lvl); g = 8'(fall_lvl); b = 8'(v);
			end
			hsv2rgb_pkg::SECTOR_BLUE: begin
				r = 8'(rise_lvl); g = 8'(low_lvl); b = 8'(v);
			end
			default: begin
				r = 8'(v); g = 8'(low_lvl); b = 8'(fall_lvl);
			end
		endcase
		if (fmt == hsv2rgb_pkg::FMT_RGB565)
			return {8'h00, r[7:3], g[7:2], b[7:3]};
		return {r, g, b};
	endfunction

	// Random pixel, biased towards sector edges and level extremes
	function automatic hsv_pixel_t random_pixel();
		hsv_pixel_t  px;
		int unsigned edge_hue;
		px.hue = HUE_W'($urandom_range(0, 65535));
		px.sat = LEVEL_W'($urandom_range(0, 255));
		px.bright = LEVEL_W'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
			0, 1: begin
				edge_hue = $urandom_range(0, 5) * hsv2rgb_pkg::SECTOR_DEGREES
					+ ($urandom_range(0, 1) ? hsv2rgb_pkg::SECTOR_DEGREES - 1 : 0)
					+ $urandom_range(0, 181) * hsv2rgb_pkg::HUE_FULL_TURN;
				px.hue = HUE_W'(edge_hue);
			end
			2: px.hue = HUE_W'($urandom_range(0, hsv2rgb_pkg::HUE_FULL_TURN - 1));
			3: begin
				px.sat = $urandom_range(0, 1) ? 8'hff : 8'h00;
				px.bright = $urandom_range(0, 1) ? 8'hff : 8'h00;
			end
			default: ;
		endcase
		return px;
	endfunction

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d pixels outstanding",
				cycle_count, pixels_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Input driver: record accepted items, then present the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				pixels_due.push_back(rgb_from_hsv({hue_degrees, sat_level, bright_level},
					format_sel));
			if (!in_valid || !in_stall) begin
				if (pixels_to_send.size() > 0
					&& (steady_flow || $urandom_range(0, 99) >= IDLE_PCT)) begin
					hsv_pixel_t px;
					px = pixels_to_send.pop_front();
					hue_degrees <= px.hue;
					sat_level <= px.sat;
					bright_level <= px.bright;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: stall at random and check each item against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pixels_due.size() == 0) begin
					$error("pixel_word: unexpected item %06h with nothing expected", pixel_word);
					error_count++;
				end else begin
					logic [PIXEL_W-1:0] want;
					want = pixels_due.pop_front();
					if (pixel_word !== want) begin
						$error("pixel_word mismatch: expected %06h, actual %06h",
							want, pixel_word);
						error_count++;
					end
					pixels_seen++;
					if (format_sel == hsv2rgb_pkg::FMT_RGB565)
						rgb565_seen++;
				end
			end
			out_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Hold until every sent item has come back, then let the pipeline settle;
	// sample between edges so that the driver's updates have landed
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pixels_to_send.size() != 0 || in_valid || pixels_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the format register while the block is idle
	task automatic write_format(input logic fmt);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= fmt;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		format_sel = fmt;
		format_writes++;
		@(negedge clk);
	endtask

	task automatic queue_random(input int unsigned count);
		repeat (count) pixels_to_send.push_back(random_pixel());
	endtask

	// Stimulus sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed pixels: each sector, its edges, hue wrap and level extremes
		write_format(hsv2rgb_pkg::FMT_RGB888);
		pixels_to_send.push_back('{16'd0,     8'd255, 8'd255});
		pixels_to_send.push_back('{16'd60,    8'd255, 8'd255});
		pixels_to_send.push_back('{16'd120,   8'd255, 8'd255});
		pixels_to_send.push_back('{16'd180,   8'd255, 8'd255});
		pixels_to_send.push_back('{16'd240,   8'd255, 8'd255});
		pixels_to_send.push_back('{16'd300,   8'd255, 8'd255});
		pixels_to_send.push_back('{16'd359,   8'd255, 8'd255});
		pixels_to_send.push_back('{16'd360,   8'd255, 8'd255});
		pixels_to_send.push_back('{16'd65535, 8'd255, 8'd255});
		pixels_to_send.push_back('{16'd65520, 8'd255, 8'd255});
		pixels_to_send.push_back('{16'd65519, 8'd37,  8'd99});
		pixels_to_send.push_back('{16'd59,    8'd255, 8'd200});
		pixels_to_send.push_back('{16'd61,    8'd128, 8'd200});
		pixels_to_send.push_back('{16'd119,   8'd200, 8'd77});
		pixels_to_send.push_back('{16'd150,   8'd255, 8'd255});
		pixels_to_send.push_back('{16'd210,   8'd100, 8'd255});
		pixels_to_send.push_back('{16'd270,   8'd1,   8'd254});
		pixels_to_send.push_back('{16'd330,   8'd254, 8'd1});
		pixels_to_send.push_back('{16'd0,     8'd0,   8'd255});
		pixels_to_send.push_back('{16'd200,   8'd0,   8'd128});
		pixels_to_send.push_back('{16'd45,    8'd255, 8'd0});
		pixels_to_send.push_back('{16'd0,     8'd0,   8'd0});
		pixels_to_send.push_back('{16'd30,    8'd255, 8'd255});
		pixels_to_send.push_back('{16'd90,    8'd255, 8'd255});
		wait_drained();

		// Random phases, alternating formats; one runs with no idling at all
		write_format(hsv2rgb_pkg::FMT_RGB565);
		queue_random(PHASE_ITEMS);
		wait_drained();

		write_format(hsv2rgb_pkg::FMT_RGB888);
		steady_flow = 1'b1;
		queue_random(PHASE_ITEMS);
		wait_drained();
		steady_flow = 1'b0;

		write_format(hsv2rgb_pkg::FMT_RGB565);
		queue_random(PHASE_ITEMS);
		wait_drained();

		write_format(hsv2rgb_pkg::FMT_RGB888);
		queue_random(PHASE_ITEMS);
		wait_drained();

		$display("Checked %0d pixels (%0d as RGB565, %0d as RGB888) over %0d format writes",
			pixels_seen, rgb565_seen, pixels_seen - rgb565_seen, format_writes);
		$display("Hue wrap, sector edges and level extremes covered; %0d mismatches",
			error_count);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/hsv2rgb_pkg.sv
src/hsv2rgb_sector.sv
src/hsv2rgb_level.sv
src/hsv_to_rgb_converter_core.sv
tb/hsv_to_rgb_converter_core_tb.sv
